FILE: src/lfa_pkg.sv
package lfa_pkg;

	// Sizing
	localparam int MAX_FRAMES = 1024;
	localparam int PAGE_BYTES = 256;
	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
	localparam int MEM_W      = 19;
	localparam int FRAME_W    = 10;
	localparam int ADDR_W     = $clog2(MAX_FRAMES);
	localparam int CNT_W      = $clog2(MAX_FRAMES) + 1;
	localparam int RAW_W      = MEM_W - PAGE_SHIFT;

	localparam logic [MEM_W-1:0] MEM_BYTES_RST = MEM_W'(262144);

	typedef enum logic {
		REQ_ALLOC = 1'b0,
		REQ_FREE  = 1'b1
	} req_type_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		req_type_t          req_type;
		logic [FRAME_W-1:0] frame_in;
	} req_t;

	typedef struct packed {
		logic [FRAME_W-1:0] frame_out;
		status_t            status;
	} rsp_t;

	typedef enum logic {
		S_IDLE,
		S_POP
	} state_t;

endpackage

FILE: src/lfa_stack_ram.sv
module lfa_stack_ram
	import lfa_pkg::*;
(
	input  logic               clk,
	input  logic               we,
	input  logic [ADDR_W-1:0]  waddr,
	input  logic [FRAME_W-1:0] wdata,
	input  logic               re,
	input  logic [ADDR_W-1:0]  raddr,
	output logic [FRAME_W-1:0] rdata
);

	logic [FRAME_W-1:0] mem_q [MAX_FRAMES];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: src/lfa_size_reg.sv
module lfa_size_reg
	import lfa_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [MEM_W-1:0] wdata,
	output logic [CNT_W-1:0] frame_total
);

	logic [MEM_W-1:0] mem_bytes_q;
	logic [RAW_W-1:0] raw_frames;

	// Size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_bytes_q <= MEM_BYTES_RST;
		end else if (wr) begin
			mem_bytes_q <= wdata;
		end
	end

	// Frames = bytes / page size, capped at the stack depth
	assign raw_frames = mem_bytes_q[MEM_W-1:PAGE_SHIFT];

	always_comb begin
		if (32'(raw_frames) > 32'(MAX_FRAMES)) begin
			frame_total = CNT_W'(MAX_FRAMES);
		end else begin
			frame_total = CNT_W'(raw_frames);
		end
	end

endmodule

FILE: src/lifo_frame_allocator.sv
// Channel  Direction  Handshake          Beat
// req      in         req_valid/stall    req_t  {req_type, frame_in}
// rsp      out        rsp_valid/stall    rsp_t  {frame_out, status}
// cfg      in         cfg_valid/ready    mem_bytes, 19 bits
//
// A free, or an allocate served from never-issued frames, is answered from S_IDLE.
// An allocate that pops a returned frame also passes through S_POP: the stack RAM
// read is registered, and the next request waits for it.
// After reset or a size write the returned stack is empty and frames are
// handed out from 0 upward; no RAM clearing pass is needed.
// A held response stalls the request side only when the output register is full.
module lifo_frame_allocator
	import lfa_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  req_t             req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output rsp_t             rsp,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [MEM_W-1:0] cfg_wdata
);

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d, cnt_dec;
	logic [CNT_W-1:0]   fresh_q, fresh_d;
	logic [CNT_W-1:0]   frame_total;
	logic               rsp_valid_q;
	rsp_t               rsp_q, rsp_d;
	logic               load_rsp;
	logic               slot_free;
	logic               cfg_wr;
	logic               ram_we, ram_re;
	logic [FRAME_W-1:0] ram_rdata;

	assign cfg_ready = (state_q == S_IDLE);
	assign cfg_wr    = cfg_valid && cfg_ready;

	lfa_size_reg u_size (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr          (cfg_wr),
		.wdata       (cfg_wdata),
		.frame_total (frame_total)
	);

	// Stack of returned frames; a push always lands before a later pop reads
	lfa_stack_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q[ADDR_W-1:0]),
		.wdata (req.frame_in),
		.re    (ram_re),
		.raddr (cnt_dec[ADDR_W-1:0]),
		.rdata (ram_rdata)
	);

	assign cnt_dec   = cnt_q - 1'b1;
	assign slot_free = !rsp_valid_q || !rsp_stall;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, stack and fresh pointer updates, response build
	always_comb begin
		state_d   = state_q;
		req_stall = 1'b1;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		load_rsp  = 1'b0;
		rsp_d     = '{frame_out: '0, status: ST_OK};
		cnt_d     = cnt_q;
		fresh_d   = fresh_q;
		unique case (state_q)
			S_IDLE: begin
				req_stall = !slot_free;
				if (req_valid && slot_free) begin
					if (req.req_type == REQ_FREE) begin
						load_rsp = 1'b1;
						if (cnt_q >= CNT_W'(MAX_FRAMES)) begin
							rsp_d.status = ST_FULL;
						end else begin
							ram_we = 1'b1;
							cnt_d  = cnt_q + 1'b1;
						end
					end else if (cnt_q != '0) begin
						ram_re  = 1'b1;
						cnt_d   = cnt_dec;
						state_d = S_POP;
					end else if (fresh_q < frame_total) begin
						load_rsp        = 1'b1;
						rsp_d.frame_out = FRAME_W'(fresh_q);
						fresh_d         = fresh_q + 1'b1;
					end else begin
						load_rsp     = 1'b1;
						rsp_d.status = ST_EMPTY;
					end
				end
			end
			S_POP: begin
				load_rsp        = 1'b1;
				rsp_d.frame_out = ram_rdata;
				state_d         = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Stack count and fresh pointer; a size write reformats the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			fresh_q <= '0;
		end else if (cfg_wr) begin
			cnt_q   <= '0;
			fresh_q <= '0;
		end else begin
			cnt_q   <= cnt_d;
			fresh_q <= fresh_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_rsp) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: test/lifo_frame_allocator_chk.sv
`timescale 1ns / 100ps

// Watches the request, response and size channels, keeps a shadow of the free
// list and checks every response beat against the oldest outstanding prediction.
module lifo_frame_allocator_chk
	import lfa_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  logic             req_stall,
	input  req_t             req,
	input  logic             rsp_valid,
	input  logic             rsp_stall,
	input  rsp_t             rsp,
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  logic [MEM_W-1:0] cfg_wdata,
	output int               outstanding,
	output int               fail_count
);

	// Shadow of the allocator state
	logic [FRAME_W-1:0] freed_frames [MAX_FRAMES];
	logic [CNT_W-1:0]   freed_count;
	logic [CNT_W-1:0]   next_fresh;
	logic [MEM_W-1:0]   mem_size;

	rsp_t due_rsp_q [$];
	int   mismatch_total;

	// Frames available from the size register, capped at the list depth
	function automatic int unsigned frame_limit();
		int unsigned n;
		n = mem_size / PAGE_BYTES;
		if (n > MAX_FRAMES)
			n = MAX_FRAMES;
		return n;
	endfunction

	// Applies one request to the shadow and returns the response it should give
	function automatic rsp_t serve_request(req_t r);
		rsp_t o;
		o.frame_out = '0;
		o.status    = ST_OK;
		if (r.req_type == REQ_ALLOC) begin
			if (freed_count != 0) begin
				freed_count = freed_count - 1'b1;
				o.frame_out = freed_frames[freed_count[ADDR_W-1:0]];
			end else if (next_fresh < frame_limit()) begin
				o.frame_out = next_fresh[FRAME_W-1:0];
				next_fresh  = next_fresh + 1'b1;
			end else begin
				o.status = ST_EMPTY;
			end
		end else begin
			if (freed_count >= MAX_FRAMES) begin
				o.status = ST_FULL;
			end else begin
				freed_frames[freed_count[ADDR_W-1:0]] = r.frame_in;
				freed_count = freed_count + 1'b1;
			end
		end
		return o;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t: %s mismatch, got %0d expected %0d", $time, what, got, want);
		mismatch_total++;
	endtask

	// Response check first: a beat leaving now belongs to an earlier request
	always @(posedge clk or negedge arst_n) begin : watch
		rsp_t want;
		if (!arst_n) begin
			mem_size       = MEM_BYTES_RST;
			freed_count    = '0;
			next_fresh     = '0;
			mismatch_total = 0;
			due_rsp_q.delete();
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (due_rsp_q.size() == 0) begin
					report_mismatch("unexpected response beat, frame", rsp.frame_out, -1);
				end else begin
					want = due_rsp_q.pop_front();
					if (rsp.frame_out !== want.frame_out)
						report_mismatch("frame_out", rsp.frame_out, want.frame_out);
					if (rsp.status !== want.status)
						report_mismatch("status", rsp.status, want.status);
				end
			end
			// Size write reformats the list
			if (cfg_valid && cfg_ready) begin
				mem_size    = cfg_wdata;
				freed_count = '0;
				next_fresh  = '0;
			end
			if (req_valid && !req_stall)
				due_rsp_q.push_back(serve_request(req));
		end
		outstanding <= due_rsp_q.size();
		fail_count  <= mismatch_total;
	end

endmodule

FILE: test/lifo_frame_allocator_tb.sv
`timescale 1ns / 100ps

module lifo_frame_allocator_tb;
	import lfa_pkg::*;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             req_valid = 1'b0;
	logic             req_stall;
	req_t             req       = '0;
	logic             rsp_valid;
	logic             rsp_stall = 1'b0;
	rsp_t             rsp;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [MEM_W-1:0] cfg_wdata = '0;

	int   outstanding;
	int   fail_count;
	int   tx_idle_pct = 0;
	int   rx_idle_pct = 0;
	logic hold_req    = 1'b0;
	logic hold_done   = 1'b0;
	int   hold_left   = 0;

	lifo_frame_allocator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_wdata (cfg_wdata)
	);

	lifo_frame_allocator_chk u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_wdata   (cfg_wdata),
		.outstanding (outstanding),
		.fail_count  (fail_count)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Response side: one long hold-off on request, otherwise random stalls
	always @(posedge clk) begin
		if (hold_left != 0) begin
			rsp_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_done) begin
			rsp_stall <= 1'b1;
			hold_left <= 80;
			hold_done <= 1'b1;
		end else begin
			rsp_stall <= (rx_idle_pct != 0) && ($urandom_range(0, 99) < rx_idle_pct);
		end
	end

	// Offers one request beat, with random gaps, and waits for it to be taken
	task automatic send_req(input req_type_t kind, input logic [FRAME_W-1:0] frame);
		while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= '{req_type: kind, frame_in: frame};
		do
			@(posedge clk);
		while (req_stall);
	endtask

	// Drains all outstanding responses, then allows for a pop still in flight
	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_size(input logic [MEM_W-1:0] bytes);
		drain();
		cfg_valid <= 1'b1;
		cfg_wdata <= bytes;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Random allocate/free mix; most frees return low frame numbers
	task automatic run_mix(input int count, input int free_pct);
		logic [FRAME_W-1:0] frame;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 3) == 0)
				frame = FRAME_W'($urandom_range(0, MAX_FRAMES - 1));
			else
				frame = FRAME_W'($urandom_range(0, 31));
			if ($urandom_range(0, 99) < free_pct)
				send_req(REQ_FREE, frame);
			else
				send_req(REQ_ALLOC, FRAME_W'($urandom));
		end
	endtask

	initial begin
		tx_idle_pct <= 19;
		rx_idle_pct <= 55;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset size: fresh frames, then pops of returned ones
		send_req(REQ_ALLOC, '0);
		send_req(REQ_ALLOC, '0);
		send_req(REQ_FREE, 10'h3FF);
		send_req(REQ_FREE, 10'h000);
		send_req(REQ_ALLOC, '0);
		send_req(REQ_ALLOC, '0);
		send_req(REQ_ALLOC, '0);
		send_req(REQ_FREE, 10'h2AA);
		send_req(REQ_FREE, 10'h155);
		send_req(REQ_ALLOC, '0);
		send_req(REQ_ALLOC, 10'h3FF);

		// No frames at all: allocate empty, a free still pushes
		write_size('0);
		send_req(REQ_ALLOC, '0);
		send_req(REQ_FREE, 10'd7);
		send_req(REQ_ALLOC, '0);
		send_req(REQ_ALLOC, '0);

		// Single frame, with a duplicate free
		write_size(MEM_W'(PAGE_BYTES));
		send_req(REQ_ALLOC, '0);
		send_req(REQ_ALLOC, '0);
		send_req(REQ_FREE, '0);
		send_req(REQ_FREE, '0);
		send_req(REQ_ALLOC, '0);
		send_req(REQ_ALLOC, '0);
		send_req(REQ_ALLOC, '0);

		// Just under one page
		write_size(MEM_W'(PAGE_BYTES - 1));
		send_req(REQ_ALLOC, '0);

		// Unaligned size, two frames
		write_size(MEM_W'(3 * PAGE_BYTES - 1));
		send_req(REQ_ALLOC, '0);
		send_req(REQ_ALLOC, '0);
		send_req(REQ_ALLOC, '0);

		// Largest size saturates the frame count; receiver holds off for a while
		write_size('1);
		hold_req <= 1'b1;
		run_mix(250, 50);

		// Small random sizes, sender now the slow side
		tx_idle_pct <= 55;
		rx_idle_pct <= 19;
		write_size(MEM_W'($urandom_range(0, 4095)));
		run_mix(100, 50);
		write_size(MEM_W'($urandom_range(0, 4095)));
		run_mix(100, 40);

		// Back-to-back: fill the returned stack past full
		tx_idle_pct <= 0;
		rx_idle_pct <= 0;
		write_size(MEM_BYTES_RST);
		for (int i = 0; i < MAX_FRAMES + 6; i++)
			send_req(REQ_FREE, FRAME_W'($urandom));
		run_mix(60, 50);

		drain();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: files.f
src/lfa_pkg.sv
src/lfa_stack_ram.sv
src/lfa_size_reg.sv
src/lifo_frame_allocator.sv
test/lifo_frame_allocator_chk.sv
test/lifo_frame_allocator_tb.sv
